### rtl/triangle_quad_barycentric_shade_unit_assert.svh
// Assertion macros for the triangle quad shade unit.
// Depends on nothing; expects signals named clk and rst in the including module.
`ifndef TRIANGLE_QUAD_BARYCENTRIC_SHADE_UNIT_ASSERT_SVH
`define TRIANGLE_QUAD_BARYCENTRIC_SHADE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define TQBSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("shade unit check failed");
`define TQBSU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("shade unit reset check failed");
`else
`define TQBSU_ASSERT(lbl, prop)
`define TQBSU_ASSERT_RST(lbl, prop)
`endif

`endif

### rtl/qbs_pkg.sv
// Shared constants and types for the triangle quad shade unit.
// Depends on nothing.
package qbs_pkg;

  localparam int LANES = 4;
  localparam int EDGES = 3;
  localparam int DEPTH_BITS = 32;
  localparam int HALF_BITS = 16;
  localparam int DIV_STEPS = DEPTH_BITS;
  localparam int PRE_STAGES = 5;
  localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS + 1;

  typedef logic [DEPTH_BITS-1:0] depth_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

endpackage

### rtl/triangle_quad_barycentric_shade_unit.sv
// Words pass the input, edge set-up, edge function, product, divider and merge stages.
// One word per cycle unless stalled; each lane's 32 one-bit divider steps are pipelined.
// Each stage advances when it is empty or its successor advances, so bubbles close up.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on qbs_pkg, qbs_setup, qbs_lane and the assertion macro header.
`include "triangle_quad_barycentric_shade_unit_assert.svh"
module triangle_quad_barycentric_shade_unit import qbs_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] vert1_x,
  input  logic signed [COORD_BITS-1:0] vert1_y,
  input  logic signed [COORD_BITS-1:0] vert2_x,
  input  logic signed [COORD_BITS-1:0] vert2_y,
  input  logic signed [COORD_BITS-1:0] vert3_x,
  input  logic signed [COORD_BITS-1:0] vert3_y,
  input  depth_t                       depth_a,
  input  depth_t                       depth_b,
  input  depth_t                       depth_c,
  input  logic signed [COORD_BITS-1:0] quad_x,
  input  logic signed [COORD_BITS-1:0] quad_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [LANES-1:0]             lane_mask,
  output depth_t                       value_lane0,
  output depth_t                       value_lane1,
  output depth_t                       value_lane2,
  output depth_t                       value_lane3,
  output logic                         degenerate
);

  localparam int CB = COORD_BITS;
  localparam int W = 2 * CB + 5;
  localparam int LAST = NUM_STAGES - 1;

  pipe_ctrl_t             ctrl;
  logic [NUM_STAGES-1:0]  vld;
  logic [NUM_STAGES-1:0]  vld_next;
  logic signed [CB-1:0]   p1x, p1y, p2x, p2y, p3x, p3y, qx, qy;
  depth_t                 dep0 [EDGES];
  depth_t                 dep1 [EDGES];
  depth_t                 dep2 [EDGES];
  logic signed [W-1:0]    wt [LANES][EDGES];
  logic signed [W-1:0]    esum;
  logic [LAST-1:3]        dg;
  logic [LANES-1:0]       hits;
  depth_t                 quots [LANES];
  logic [LANES-1:0]       lane_nz;

  assign ctrl.en[LAST] = !vld[LAST] || !out_stall;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign ctrl.en[k] = !vld[k] || ctrl.en[k+1];
  end

  assign vld_next = {vld[LAST-1:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld_next & ctrl.en) | (vld & ~ctrl.en);
    end
  end

  assign in_stall  = !ctrl.en[0];
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      p1x <= vert1_x;
      p1y <= vert1_y;
      p2x <= vert2_x;
      p2y <= vert2_y;
      p3x <= vert3_x;
      p3y <= vert3_y;
      qx  <= quad_x;
      qy  <= quad_y;
      dep0[0] <= depth_a;
      dep0[1] <= depth_b;
      dep0[2] <= depth_c;
    end
    if (ctrl.en[1]) begin
      dep1 <= dep0;
    end
    if (ctrl.en[2]) begin
      dep2 <= dep1;
    end
  end

  qbs_setup #(.CB(CB), .W(W)) u_setup (
    .clk  (clk),
    .ctrl (ctrl),
    .v1x  (p1x),
    .v1y  (p1y),
    .v2x  (p2x),
    .v2y  (p2y),
    .v3x  (p3x),
    .v3y  (p3y),
    .qx   (qx),
    .qy   (qy),
    .w    (wt),
    .s    (esum)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    qbs_lane #(.W(W)) u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .w    (wt[i]),
      .s    (esum),
      .d    (dep2),
      .hit  (hits[i]),
      .quot (quots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      dg[3] <= (esum == '0);
    end
  end

  for (genvar k = 4; k < LAST; k++) begin : g_dg
    always_ff @(posedge clk) begin
      if (ctrl.en[k]) begin
        dg[k] <= dg[k-1];
      end
    end
  end

  // The merge stage zeroes every lane that is not covered.
  always_ff @(posedge clk) begin
    if (ctrl.en[LAST]) begin
      lane_mask   <= hits;
      value_lane0 <= hits[0] ? quots[0] : '0;
      value_lane1 <= hits[1] ? quots[1] : '0;
      value_lane2 <= hits[2] ? quots[2] : '0;
      value_lane3 <= hits[3] ? quots[3] : '0;
      degenerate  <= dg[LAST-1];
    end
  end

  assign lane_nz = {value_lane3 != '0, value_lane2 != '0, value_lane1 != '0, value_lane0 != '0};

  `TQBSU_ASSERT(a_degen_no_mask, out_valid && degenerate |-> lane_mask == '0)
  `TQBSU_ASSERT(a_masked_zero, out_valid |-> (lane_nz & ~lane_mask) == '0)
  `TQBSU_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall && (&vld))
  `TQBSU_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !in_stall)

endmodule

### rtl/qbs_setup.sv
// Edge set-up and per-lane edge function evaluation, two pipeline stages.
// Depends on qbs_pkg.
module qbs_setup import qbs_pkg::*; #(
  parameter int CB = 13,
  parameter int W = 2 * CB + 5
) (
  input  logic                 clk,
  input  pipe_ctrl_t           ctrl,
  input  logic signed [CB-1:0] v1x,
  input  logic signed [CB-1:0] v1y,
  input  logic signed [CB-1:0] v2x,
  input  logic signed [CB-1:0] v2y,
  input  logic signed [CB-1:0] v3x,
  input  logic signed [CB-1:0] v3y,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  output logic signed [W-1:0]  w [LANES][EDGES],
  output logic signed [W-1:0]  s
);

  logic signed [CB-1:0]   pa_x [EDGES];
  logic signed [CB-1:0]   pa_y [EDGES];
  logic signed [CB-1:0]   pb_x [EDGES];
  logic signed [CB-1:0]   pb_y [EDGES];
  logic signed [2*CB-1:0] m1 [EDGES];
  logic signed [2*CB-1:0] m2 [EDGES];
  logic signed [CB:0]     ea [EDGES];
  logic signed [CB:0]     eb [EDGES];
  logic signed [2*CB:0]   ec [EDGES];
  logic signed [CB-1:0]   qx1;
  logic signed [CB-1:0]   qy1;
  logic signed [CB+1:0]   ylane;

  // Edge functions use (p2,p3), (p3,p1) and (p1,p2).
  assign pa_x[0] = v2x;
  assign pa_y[0] = v2y;
  assign pb_x[0] = v3x;
  assign pb_y[0] = v3y;
  assign pa_x[1] = v3x;
  assign pa_y[1] = v3y;
  assign pb_x[1] = v1x;
  assign pb_y[1] = v1y;
  assign pa_x[2] = v1x;
  assign pa_y[2] = v1y;
  assign pb_x[2] = v2x;
  assign pb_y[2] = v2y;

  for (genvar j = 0; j < EDGES; j++) begin : g_edge
    assign m1[j] = (2*CB)'(pb_x[j]) * (2*CB)'(pa_y[j]);
    assign m2[j] = (2*CB)'(pa_x[j]) * (2*CB)'(pb_y[j]);
    always_ff @(posedge clk) begin
      if (ctrl.en[1]) begin
        ea[j] <= (CB+1)'(pb_y[j]) - (CB+1)'(pa_y[j]);
        eb[j] <= (CB+1)'(pa_x[j]) - (CB+1)'(pb_x[j]);
        ec[j] <= (2*CB+1)'(m1[j]) - (2*CB+1)'(m2[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      qx1 <= qx;
      qy1 <= qy;
    end
  end

  assign ylane = (CB+2)'(qy1);

  // The edge sum is the same for every lane: the A and B terms cancel.
  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      s <= W'(ec[0]) + W'(ec[1]) + W'(ec[2]);
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [CB+1:0]   xlane;
    logic signed [2*CB+2:0] px [EDGES];
    logic signed [2*CB+2:0] py [EDGES];
    assign xlane = (CB+2)'(qx1) + (CB+2)'(i);
    for (genvar j = 0; j < EDGES; j++) begin : g_e
      assign px[j] = (2*CB+3)'(ea[j]) * (2*CB+3)'(xlane);
      assign py[j] = (2*CB+3)'(eb[j]) * (2*CB+3)'(ylane);
      always_ff @(posedge clk) begin
        if (ctrl.en[2]) begin
          w[i][j] <= W'(px[j]) + W'(py[j]) + W'(ec[j]);
        end
      end
    end
  end

endmodule

### rtl/qbs_lane.sv
// One lane: coverage test, weighted depth sum and a pipelined restoring divider.
// Depends on qbs_pkg.
module qbs_lane import qbs_pkg::*; #(
  parameter int W = 31
) (
  input  logic                clk,
  input  pipe_ctrl_t          ctrl,
  input  logic signed [W-1:0] w [EDGES],
  input  logic signed [W-1:0] s,
  input  depth_t              d [EDGES],
  output logic                hit,
  output depth_t              quot
);

  localparam int DW = W - 1;
  localparam int PW = HALF_BITS + DW;
  localparam int SW = PW + 2;
  localparam int NW = SW + HALF_BITS + 1;

  logic [DW-1:0] wu [EDGES];
  logic [PW-1:0] ph [EDGES];
  logic [PW-1:0] pl [EDGES];
  logic [PW-1:0] ph3 [EDGES];
  logic [PW-1:0] pl3 [EDGES];
  logic          cov;
  logic          hit3;
  logic [DW-1:0] s3;
  logic [SW-1:0] sh;
  logic [SW-1:0] sl;
  logic [NW-1:0] num;
  logic [DW-1:0] rem [DIV_STEPS+1];
  depth_t        lq [DIV_STEPS+1];
  logic [DW-1:0] den [DIV_STEPS+1];
  logic          hq [DIV_STEPS+1];

  assign cov = !w[0][W-1] && !w[1][W-1] && !w[2][W-1] && (s != '0);

  for (genvar j = 0; j < EDGES; j++) begin : g_mul
    assign wu[j] = w[j][DW-1:0];
    assign ph[j] = PW'(d[j][DEPTH_BITS-1:HALF_BITS]) * PW'(wu[j]);
    assign pl[j] = PW'(d[j][HALF_BITS-1:0]) * PW'(wu[j]);
    always_ff @(posedge clk) begin
      if (ctrl.en[3]) begin
        ph3[j] <= ph[j];
        pl3[j] <= pl[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      hit3 <= cov;
      s3   <= s[DW-1:0];
    end
  end

  assign sh  = SW'(ph3[0]) + SW'(ph3[1]) + SW'(ph3[2]);
  assign sl  = SW'(pl3[0]) + SW'(pl3[1]) + SW'(pl3[2]);
  assign num = (NW'(sh) << HALF_BITS) + NW'(sl);

  // The quotient fits in one word, so the upper part starts below the divisor.
  always_ff @(posedge clk) begin
    if (ctrl.en[PRE_STAGES-1]) begin
      rem[0] <= DW'(num >> DEPTH_BITS);
      lq[0]  <= num[DEPTH_BITS-1:0];
      den[0] <= s3;
      hq[0]  <= hit3;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem[k-1], lq[k-1][DEPTH_BITS-1]};
    assign ge = t >= {1'b0, den[k-1]};
    always_ff @(posedge clk) begin
      if (ctrl.en[PRE_STAGES-1+k]) begin
        rem[k] <= ge ? DW'(t - {1'b0, den[k-1]}) : DW'(t);
        lq[k]  <= {lq[k-1][DEPTH_BITS-2:0], ge};
        den[k] <= den[k-1];
        hq[k]  <= hq[k-1];
      end
    end
  end

  assign hit  = hq[DIV_STEPS];
  assign quot = lq[DIV_STEPS];

endmodule
